FILE: sv/mwm_pkg.sv
// Package for the mecanum wheel mixer: widths, codes, sine table and output rounding.
package mwm_pkg;

    localparam int SCALE_FRAC_BITS = 14;
    localparam int TRIG_FRAC_BITS  = 15;
    localparam int DRIVE_BITS      = 16;

    localparam int ACTION_W    = 3;
    localparam int VALUE_W     = 16;
    localparam int HEADING_W   = 9;
    localparam int SCALE_W     = 16;
    localparam int CFG_INDEX_W = 2;

    // Operand and product widths along the pipe
    localparam int OPA_W  = VALUE_W + 1;        // p - y, p + y, -p
    localparam int OPB_W  = SCALE_W + 2;        // scale or signed Q1.15 trig, +-1.0 inclusive
    localparam int PROD_W = OPA_W + OPB_W;      // first products
    localparam int SPIN_W = VALUE_W + SCALE_W + 1;
    localparam int MIX_W  = PROD_W + 1;         // vy +- vx
    localparam int PIR_W  = 32;                 // |vy +- vx| < 2^31 always
    localparam int SUM_W  = 50;                 // wheel sums before rounding

    localparam int LIN_SHIFT = SCALE_FRAC_BITS;
    localparam int PIR_SHIFT = SCALE_FRAC_BITS + TRIG_FRAC_BITS;

    localparam logic signed [SUM_W-1:0] LIN_BIAS  = SUM_W'((64'sd1 <<< LIN_SHIFT) - 64'sd1);
    localparam logic signed [SUM_W-1:0] PIR_BIAS  = SUM_W'((64'sd1 <<< PIR_SHIFT) - 64'sd1);
    localparam logic signed [SUM_W-1:0] DRIVE_MAX = SUM_W'((64'sd1 <<< (DRIVE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] DRIVE_MIN = SUM_W'(-(64'sd1 <<< (DRIVE_BITS - 1)));

    typedef logic [ACTION_W-1:0]           action_t;
    typedef logic signed [VALUE_W-1:0]     value_t;
    typedef logic [HEADING_W-1:0]          heading_t;
    typedef logic [SCALE_W-1:0]            scale_t;
    typedef logic [CFG_INDEX_W-1:0]        cfg_index_t;
    typedef logic signed [DRIVE_BITS-1:0]  drive_t;
    typedef logic signed [OPB_W-1:0]       trig_t;

    localparam action_t ACT_STOP      = 3'd0;
    localparam action_t ACT_DRIVE     = 3'd1;
    localparam action_t ACT_ROTATE    = 3'd2;
    localparam action_t ACT_TRANSLATE = 3'd3;
    localparam action_t ACT_PIROUETTE = 3'd4;

    localparam cfg_index_t REG_SPEED_SCALE     = 2'd0;
    localparam cfg_index_t REG_TRANSLATE_SCALE = 2'd1;
    localparam cfg_index_t REG_SPIN_SCALE      = 2'd2;

    localparam scale_t SCALE_RESET = 16'd16384;

    // Per-word mixing controls that ride along the pipe
    typedef struct packed {
        logic pirouette;   // trig path, wider rounding shift
        logic swap_back;   // back wheels take the opposite front value (translate)
    } mix_ctl_t;

    // sin(k deg) for k = 0..90, Q1.15, rounded half up
    function automatic logic [TRIG_FRAC_BITS+1:0] quarter_sin(input logic [6:0] k);
        logic [TRIG_FRAC_BITS+1:0] v;
        case (k)
            7'd0:  v = 17'd0;     7'd1:  v = 17'd572;   7'd2:  v = 17'd1144;
            7'd3:  v = 17'd1715;  7'd4:  v = 17'd2286;  7'd5:  v = 17'd2856;
            7'd6:  v = 17'd3425;  7'd7:  v = 17'd3993;  7'd8:  v = 17'd4560;
            7'd9:  v = 17'd5126;  7'd10: v = 17'd5690;  7'd11: v = 17'd6252;
            7'd12: v = 17'd6813;  7'd13: v = 17'd7371;  7'd14: v = 17'd7927;
            7'd15: v = 17'd8481;  7'd16: v = 17'd9032;  7'd17: v = 17'd9580;
            7'd18: v = 17'd10126; 7'd19: v = 17'd10668; 7'd20: v = 17'd11207;
            7'd21: v = 17'd11743; 7'd22: v = 17'd12275; 7'd23: v = 17'd12803;
            7'd24: v = 17'd13328; 7'd25: v = 17'd13848; 7'd26: v = 17'd14365;
            7'd27: v = 17'd14876; 7'd28: v = 17'd15384; 7'd29: v = 17'd15886;
            7'd30: v = 17'd16384; 7'd31: v = 17'd16877; 7'd32: v = 17'd17364;
            7'd33: v = 17'd17847; 7'd34: v = 17'd18324; 7'd35: v = 17'd18795;
            7'd36: v = 17'd19261; 7'd37: v = 17'd19720; 7'd38: v = 17'd20174;
            7'd39: v = 17'd20622; 7'd40: v = 17'd21063; 7'd41: v = 17'd21498;
            7'd42: v = 17'd21926; 7'd43: v = 17'd22348; 7'd44: v = 17'd22763;
            7'd45: v = 17'd23170; 7'd46: v = 17'd23571; 7'd47: v = 17'd23965;
            7'd48: v = 17'd24351; 7'd49: v = 17'd24730; 7'd50: v = 17'd25102;
            7'd51: v = 17'd25466; 7'd52: v = 17'd25822; 7'd53: v = 17'd26170;
            7'd54: v = 17'd26510; 7'd55: v = 17'd26842; 7'd56: v = 17'd27166;
            7'd57: v = 17'd27482; 7'd58: v = 17'd27789; 7'd59: v = 17'd28088;
            7'd60: v = 17'd28378; 7'd61: v = 17'd28660; 7'd62: v = 17'd28932;
            7'd63: v = 17'd29197; 7'd64: v = 17'd29452; 7'd65: v = 17'd29698;
            7'd66: v = 17'd29935; 7'd67: v = 17'd30163; 7'd68: v = 17'd30382;
            7'd69: v = 17'd30592; 7'd70: v = 17'd30792; 7'd71: v = 17'd30983;
            7'd72: v = 17'd31164; 7'd73: v = 17'd31336; 7'd74: v = 17'd31499;
            7'd75: v = 17'd31651; 7'd76: v = 17'd31795; 7'd77: v = 17'd31928;
            7'd78: v = 17'd32052; 7'd79: v = 17'd32166; 7'd80: v = 17'd32270;
            7'd81: v = 17'd32365; 7'd82: v = 17'd32449; 7'd83: v = 17'd32524;
            7'd84: v = 17'd32588; 7'd85: v = 17'd32643; 7'd86: v = 17'd32688;
            7'd87: v = 17'd32723; 7'd88: v = 17'd32748; 7'd89: v = 17'd32763;
            7'd90: v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // Signed sine for a heading already reduced to 0..359
    function automatic trig_t full_sin(input heading_t h);
        heading_t                  r;
        logic                      mirror;
        logic                      neg;
        logic [6:0]                k;
        logic [TRIG_FRAC_BITS+1:0] mag;
        if (h < 9'd90)
        begin
            r = h;           mirror = 1'b0; neg = 1'b0;
        end
        else if (h < 9'd180)
        begin
            r = h - 9'd90;   mirror = 1'b1; neg = 1'b0;
        end
        else if (h < 9'd270)
        begin
            r = h - 9'd180;  mirror = 1'b0; neg = 1'b1;
        end
        else
        begin
            r = h - 9'd270;  mirror = 1'b1; neg = 1'b1;
        end
        k   = mirror ? 7'(9'd90 - r) : r[6:0];
        mag = quarter_sin(k);
        return neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    endfunction

    // Truncate toward zero by the mode's fraction bits, then saturate
    function automatic drive_t finish(input logic signed [SUM_W-1:0] v, input logic pirouette);
        logic signed [SUM_W-1:0] biased;
        logic signed [SUM_W-1:0] q;
        if (pirouette)
        begin
            biased = v + (v[SUM_W-1] ? PIR_BIAS : '0);
            q      = biased >>> PIR_SHIFT;
        end
        else
        begin
            biased = v + (v[SUM_W-1] ? LIN_BIAS : '0);
            q      = biased >>> LIN_SHIFT;
        end
        if (q > DRIVE_MAX)
            q = DRIVE_MAX;
        else if (q < DRIVE_MIN)
            q = DRIVE_MIN;
        return q[DRIVE_BITS-1:0];
    endfunction

endpackage

FILE: sv/mwm_if.sv
// Channel interfaces of the mecanum wheel mixer: command, wheel result and register write.
interface mwm_cmd_if;
    logic                valid;
    logic                ready;
    mwm_pkg::action_t    action;
    mwm_pkg::value_t     primary_value;
    mwm_pkg::value_t     spin_value;
    mwm_pkg::heading_t   heading_deg;
    mwm_pkg::value_t     yaw_trim;

    modport source (output valid, action, primary_value, spin_value, heading_deg, yaw_trim,
                    input ready);
    modport sink   (input valid, action, primary_value, spin_value, heading_deg, yaw_trim,
                    output ready);
endinterface

interface mwm_wheel_if;
    logic              valid;
    logic              ready;
    mwm_pkg::drive_t   front_left_drive;
    mwm_pkg::drive_t   front_right_drive;
    mwm_pkg::drive_t   back_left_drive;
    mwm_pkg::drive_t   back_right_drive;

    modport source (output valid, front_left_drive, front_right_drive, back_left_drive,
                    back_right_drive, input ready);
    modport sink   (input valid, front_left_drive, front_right_drive, back_left_drive,
                    back_right_drive, output ready);
endinterface

interface mwm_cfg_if;
    logic                  valid;
    logic                  ready;
    mwm_pkg::cfg_index_t   index;
    mwm_pkg::scale_t       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/mecanum_wheel_mixer.sv
// Mecanum wheel mixer top level: six-stage pipeline from motion command to four wheel drives.
//
// Usage
//   cmd   : one motion command word per handshake (action, primary_value, spin_value,
//           heading_deg, yaw_trim). Accepted when cmd.valid and cmd.ready are high.
//   wheel : one result word per command (FL, FR, BL, BR drive values, saturated int16).
//   cfg   : register writes, index 0 speed_scale, 1 translate_scale, 2 spin_scale,
//           all unsigned Q2.14. Always ready; other indexes are dropped. Write only
//           while no command is in flight.
// Timing
//   wheel.valid rises when an accepted command reaches stage 6; stage 1 loads at the
//   accepting edge. Throughput is one word per cycle when not stalled; the depth is set by
//   the two multipliers (scale/trig products, then translate scale on the pirouette mix).
// Stall
//   All six stages advance together whenever the output register is empty or being
//   taken. When wheel.ready is low with a word waiting, the whole pipe holds and
//   cmd.ready drops; nothing is dropped or repeated.
// Reset
//   rst_n clears every stage valid and loads all three scales with 1.0 (16384).
module mecanum_wheel_mixer
(
    input  logic               clk,
    input  logic               rst_n,
    mwm_cmd_if.sink            cmd,
    mwm_wheel_if.source        wheel,
    mwm_cfg_if.sink            cfg
);

    // ------------------------------------------------------------------
    // Scale registers
    // ------------------------------------------------------------------
    mwm_pkg::scale_t speed_scale_reg,     speed_scale_next;
    mwm_pkg::scale_t translate_scale_reg, translate_scale_next;
    mwm_pkg::scale_t spin_scale_reg,      spin_scale_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        speed_scale_next     = speed_scale_reg;
        translate_scale_next = translate_scale_reg;
        spin_scale_next      = spin_scale_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                mwm_pkg::REG_SPEED_SCALE:     speed_scale_next     = cfg.data;
                mwm_pkg::REG_TRANSLATE_SCALE: translate_scale_next = cfg.data;
                mwm_pkg::REG_SPIN_SCALE:      spin_scale_next      = cfg.data;
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_scale_reg     <= mwm_pkg::SCALE_RESET;
            translate_scale_reg <= mwm_pkg::SCALE_RESET;
            spin_scale_reg      <= mwm_pkg::SCALE_RESET;
        end
        else
        begin
            speed_scale_reg     <= speed_scale_next;
            translate_scale_reg <= translate_scale_next;
            spin_scale_reg      <= spin_scale_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipe control: every stage moves on advance
    // ------------------------------------------------------------------
    logic advance;
    logic [5:0] valid_reg, valid_next;

    assign advance   = !valid_reg[5] || wheel.ready;
    assign cmd.ready = advance;

    assign valid_next = advance ? {valid_reg[4:0], cmd.valid} : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // ------------------------------------------------------------------
    // Stage 1: decode action, heading reduction, sine/cosine lookup
    // ------------------------------------------------------------------
    logic signed [mwm_pkg::OPA_W-1:0]   a1_reg, a1_next;
    logic signed [mwm_pkg::OPA_W-1:0]   b1_reg, b1_next;
    mwm_pkg::trig_t                     ka1_reg, ka1_next;
    mwm_pkg::trig_t                     kb1_reg, kb1_next;
    mwm_pkg::value_t                    spin1_reg, spin1_next;
    mwm_pkg::mix_ctl_t                  ctl1_reg, ctl1_next;

    mwm_pkg::heading_t                  head_red;
    mwm_pkg::heading_t                  head_cos;
    logic signed [mwm_pkg::OPA_W-1:0]   p_ext;
    logic signed [mwm_pkg::OPA_W-1:0]   y_ext;
    mwm_pkg::trig_t                     speed_op;
    mwm_pkg::trig_t                     trans_op;

    always_comb
    begin
        // headings of 360 and up lose one turn
        head_red = (cmd.heading_deg >= 9'd360) ? cmd.heading_deg - 9'd360 : cmd.heading_deg;
        head_cos = (head_red >= 9'd270) ? head_red - 9'd270 : head_red + 9'd90;

        p_ext    = mwm_pkg::OPA_W'(cmd.primary_value);
        y_ext    = mwm_pkg::OPA_W'(cmd.yaw_trim);
        speed_op = signed'({2'b00, speed_scale_reg});
        trans_op = signed'({2'b00, translate_scale_reg});

        spin1_next = cmd.spin_value;
        a1_next    = '0;
        b1_next    = '0;
        ka1_next   = '0;
        kb1_next   = '0;
        ctl1_next  = '0;
        case (cmd.action)
            mwm_pkg::ACT_DRIVE:
            begin
                a1_next  = p_ext - y_ext;
                b1_next  = p_ext + y_ext;
                ka1_next = speed_op;
                kb1_next = speed_op;
            end
            mwm_pkg::ACT_ROTATE:
            begin
                a1_next  = p_ext;
                b1_next  = -p_ext;
                ka1_next = speed_op;
                kb1_next = speed_op;
            end
            mwm_pkg::ACT_TRANSLATE:
            begin
                a1_next  = -p_ext;
                b1_next  = p_ext;
                ka1_next = trans_op;
                kb1_next = trans_op;
                ctl1_next.swap_back = 1'b1;
            end
            mwm_pkg::ACT_PIROUETTE:
            begin
                // a carries vy, b carries vx after the multiply
                a1_next  = p_ext;
                b1_next  = p_ext;
                ka1_next = mwm_pkg::full_sin(head_red);
                kb1_next = mwm_pkg::full_sin(head_cos);
                ctl1_next.pirouette = 1'b1;
            end
            default:
            begin
                // stop and unused codes: zero operands give zero wheels
                a1_next = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 2: first products (scale or trig), spin product
    // ------------------------------------------------------------------
    logic signed [mwm_pkg::PROD_W-1:0]  pa2_reg, pa2_next;
    logic signed [mwm_pkg::PROD_W-1:0]  pb2_reg, pb2_next;
    logic signed [mwm_pkg::SPIN_W-1:0]  w2_reg,  w2_next;
    mwm_pkg::mix_ctl_t                  ctl2_reg, ctl2_next;

    always_comb
    begin
        pa2_next  = mwm_pkg::PROD_W'(a1_reg) * mwm_pkg::PROD_W'(ka1_reg);
        pb2_next  = mwm_pkg::PROD_W'(b1_reg) * mwm_pkg::PROD_W'(kb1_reg);
        w2_next   = mwm_pkg::SPIN_W'(spin1_reg)
                  * mwm_pkg::SPIN_W'(signed'({1'b0, spin_scale_reg}));
        ctl2_next = ctl1_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: pirouette forms vy - vx and vy + vx
    // ------------------------------------------------------------------
    logic signed [mwm_pkg::MIX_W-1:0]   d3_reg, d3_next;
    logic signed [mwm_pkg::MIX_W-1:0]   e3_reg, e3_next;
    logic signed [mwm_pkg::SPIN_W-1:0]  w3_reg, w3_next;
    mwm_pkg::mix_ctl_t                  ctl3_reg, ctl3_next;

    always_comb
    begin
        if (ctl2_reg.pirouette)
        begin
            d3_next = mwm_pkg::MIX_W'(pa2_reg) - mwm_pkg::MIX_W'(pb2_reg);
            e3_next = mwm_pkg::MIX_W'(pa2_reg) + mwm_pkg::MIX_W'(pb2_reg);
        end
        else
        begin
            d3_next = mwm_pkg::MIX_W'(pa2_reg);
            e3_next = mwm_pkg::MIX_W'(pb2_reg);
        end
        w3_next   = w2_reg;
        ctl3_next = ctl2_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: pirouette mix times translate_scale
    // ------------------------------------------------------------------
    logic signed [mwm_pkg::SUM_W-1:0]   md4_reg, md4_next;
    logic signed [mwm_pkg::SUM_W-1:0]   me4_reg, me4_next;
    logic signed [mwm_pkg::SPIN_W-1:0]  w4_reg,  w4_next;
    mwm_pkg::mix_ctl_t                  ctl4_reg, ctl4_next;
    logic signed [mwm_pkg::SUM_W-1:0]   ts_op;

    always_comb
    begin
        ts_op = mwm_pkg::SUM_W'(signed'({1'b0, translate_scale_reg}));
        if (ctl3_reg.pirouette)
        begin
            md4_next = mwm_pkg::SUM_W'(signed'(d3_reg[mwm_pkg::PIR_W-1:0])) * ts_op;
            me4_next = mwm_pkg::SUM_W'(signed'(e3_reg[mwm_pkg::PIR_W-1:0])) * ts_op;
        end
        else
        begin
            md4_next = mwm_pkg::SUM_W'(d3_reg);
            me4_next = mwm_pkg::SUM_W'(e3_reg);
        end
        w4_next   = w3_reg;
        ctl4_next = ctl3_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: per-wheel sums
    // ------------------------------------------------------------------
    logic signed [mwm_pkg::SUM_W-1:0]   fl5_reg, fl5_next;
    logic signed [mwm_pkg::SUM_W-1:0]   fr5_reg, fr5_next;
    logic signed [mwm_pkg::SUM_W-1:0]   bl5_reg, bl5_next;
    logic signed [mwm_pkg::SUM_W-1:0]   br5_reg, br5_next;
    logic                               pir5_reg, pir5_next;
    logic signed [mwm_pkg::SUM_W-1:0]   w_shift;

    always_comb
    begin
        // spin term aligned to the trig fraction
        w_shift   = mwm_pkg::SUM_W'(w4_reg) <<< mwm_pkg::TRIG_FRAC_BITS;
        pir5_next = ctl4_reg.pirouette;
        if (ctl4_reg.pirouette)
        begin
            fl5_next = md4_reg + w_shift;
            bl5_next = me4_reg + w_shift;
            fr5_next = me4_reg - w_shift;
            br5_next = md4_reg - w_shift;
        end
        else
        begin
            fl5_next = md4_reg;
            fr5_next = me4_reg;
            bl5_next = ctl4_reg.swap_back ? me4_reg : md4_reg;
            br5_next = ctl4_reg.swap_back ? md4_reg : me4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: round toward zero, saturate; output register
    // ------------------------------------------------------------------
    mwm_pkg::drive_t fl6_reg, fl6_next;
    mwm_pkg::drive_t fr6_reg, fr6_next;
    mwm_pkg::drive_t bl6_reg, bl6_next;
    mwm_pkg::drive_t br6_reg, br6_next;

    always_comb
    begin
        fl6_next = mwm_pkg::finish(fl5_reg, pir5_reg);
        fr6_next = mwm_pkg::finish(fr5_reg, pir5_reg);
        bl6_next = mwm_pkg::finish(bl5_reg, pir5_reg);
        br6_next = mwm_pkg::finish(br5_reg, pir5_reg);
    end

    // Payload registers: no reset, load on advance
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a1_reg    <= a1_next;
            b1_reg    <= b1_next;
            ka1_reg   <= ka1_next;
            kb1_reg   <= kb1_next;
            spin1_reg <= spin1_next;
            ctl1_reg  <= ctl1_next;

            pa2_reg   <= pa2_next;
            pb2_reg   <= pb2_next;
            w2_reg    <= w2_next;
            ctl2_reg  <= ctl2_next;

            d3_reg    <= d3_next;
            e3_reg    <= e3_next;
            w3_reg    <= w3_next;
            ctl3_reg  <= ctl3_next;

            md4_reg   <= md4_next;
            me4_reg   <= me4_next;
            w4_reg    <= w4_next;
            ctl4_reg  <= ctl4_next;

            fl5_reg   <= fl5_next;
            fr5_reg   <= fr5_next;
            bl5_reg   <= bl5_next;
            br5_reg   <= br5_next;
            pir5_reg  <= pir5_next;

            fl6_reg   <= fl6_next;
            fr6_reg   <= fr6_next;
            bl6_reg   <= bl6_next;
            br6_reg   <= br6_next;
        end
    end

    assign wheel.valid             = valid_reg[5];
    assign wheel.front_left_drive  = fl6_reg;
    assign wheel.front_right_drive = fr6_reg;
    assign wheel.back_left_drive   = bl6_reg;
    assign wheel.back_right_drive  = br6_reg;

endmodule

FILE: verif/tb_mecanum_wheel_mixer.sv
// Self-checking testbench for the mecanum wheel mixer: directed table, then random phases.
`timescale 1ns / 100ps

module tb_mecanum_wheel_mixer;

    typedef longint unsigned u64_t;

    // Spare action codes behave as stop; index 3 of the register port maps to nothing
    localparam mwm_pkg::action_t    ACT_RSVD_A   = 3'd5;
    localparam mwm_pkg::action_t    ACT_RSVD_B   = 3'd6;
    localparam mwm_pkg::action_t    ACT_RSVD_C   = 3'd7;
    localparam mwm_pkg::cfg_index_t REG_UNMAPPED = 2'd3;

    localparam mwm_pkg::value_t V_MAX = 16'sh7fff;
    localparam mwm_pkg::value_t V_MIN = 16'sh8000;

    localparam u64_t PI_Q30           = 64'd3373259426;
    localparam int   LONG_HOLD_CYCLES = 80;
    localparam int   PHASE_COUNT      = 6;
    localparam int   PHASE_ITEMS      = 240;
    localparam int   DIRECTED_COUNT   = 25;

    typedef struct packed {
        mwm_pkg::action_t  action;
        mwm_pkg::value_t   primary;
        mwm_pkg::value_t   spin;
        mwm_pkg::heading_t heading;
        mwm_pkg::value_t   yaw;
    } motion_cmd_t;

    typedef struct packed {
        mwm_pkg::drive_t fl;
        mwm_pkg::drive_t fr;
        mwm_pkg::drive_t bl;
        mwm_pkg::drive_t br;
    } wheel_word_t;

    // known = 1: the wheel word is typed in; otherwise the predictor supplies it
    typedef struct packed {
        motion_cmd_t cmd;
        logic        known;
        wheel_word_t want;
    } directed_row_t;

    localparam wheel_word_t NO_WANT = '0;

    // Directed rows run at the reset scales (1.0 everywhere)
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{mwm_pkg::ACT_STOP, V_MAX, V_MIN, 9'd511, -16'sd1}, 1'b1, '0},
        '{'{mwm_pkg::ACT_DRIVE, V_MAX, 16'sd0, 9'd0, V_MAX}, 1'b1,
          '{16'sd0, V_MAX, 16'sd0, V_MAX}},
        '{'{mwm_pkg::ACT_DRIVE, V_MIN, 16'sd0, 9'd0, V_MAX}, 1'b1,
          '{V_MIN, -16'sd1, V_MIN, -16'sd1}},
        '{'{mwm_pkg::ACT_DRIVE, V_MIN, 16'sd0, 9'd0, V_MIN}, 1'b1,
          '{16'sd0, V_MIN, 16'sd0, V_MIN}},
        '{'{mwm_pkg::ACT_ROTATE, V_MAX, 16'sd0, 9'd0, 16'sd0}, 1'b1,
          '{V_MAX, -16'sd32767, V_MAX, -16'sd32767}},
        '{'{mwm_pkg::ACT_ROTATE, V_MIN, 16'sd0, 9'd0, 16'sd0}, 1'b1,
          '{V_MIN, V_MAX, V_MIN, V_MAX}},
        '{'{mwm_pkg::ACT_TRANSLATE, V_MIN, 16'sd0, 9'd0, 16'sd0}, 1'b1,
          '{V_MAX, V_MIN, V_MIN, V_MAX}},
        '{'{mwm_pkg::ACT_TRANSLATE, V_MAX, 16'sd0, 9'd0, 16'sd0}, 1'b1,
          '{-16'sd32767, V_MAX, V_MAX, -16'sd32767}},
        '{'{mwm_pkg::ACT_PIROUETTE, 16'sd16384, 16'sd0, 9'd90, 16'sd0}, 1'b1,
          '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384}},
        '{'{mwm_pkg::ACT_PIROUETTE, 16'sd16384, 16'sd0, 9'd0, 16'sd0}, 1'b1,
          '{-16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384}},
        '{'{mwm_pkg::ACT_PIROUETTE, 16'sd0, 16'sd1000, 9'd0, 16'sd0}, 1'b1,
          '{16'sd1000, -16'sd1000, 16'sd1000, -16'sd1000}},
        '{'{mwm_pkg::ACT_PIROUETTE, 16'sd0, V_MIN, 9'd123, 16'sd0}, 1'b1,
          '{V_MIN, V_MAX, V_MIN, V_MAX}},
        '{'{ACT_RSVD_C, 16'sd12345, -16'sd777, 9'd200, 16'sd4321}, 1'b1, '0},
        '{'{ACT_RSVD_A, V_MAX, V_MAX, 9'd90, V_MAX}, 1'b1, '0},
        '{'{ACT_RSVD_B, V_MIN, V_MIN, 9'd300, V_MIN}, 1'b1, '0},
        // heading past 360 wraps once
        '{'{mwm_pkg::ACT_PIROUETTE, 16'sd16384, 16'sd0, 9'd360, 16'sd0}, 1'b1,
          '{-16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384}},
        '{'{mwm_pkg::ACT_PIROUETTE, -16'sd16384, 16'sd0, 9'd450, 16'sd0}, 1'b1,
          '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384}},
        '{'{mwm_pkg::ACT_PIROUETTE, V_MAX, V_MAX, 9'd511, 16'sd0}, 1'b0, NO_WANT},
        '{'{mwm_pkg::ACT_PIROUETTE, V_MIN, V_MIN, 9'd180, 16'sd0}, 1'b0, NO_WANT},
        '{'{mwm_pkg::ACT_PIROUETTE, V_MAX, 16'sd12345, 9'd270, 16'sd0}, 1'b0, NO_WANT},
        '{'{mwm_pkg::ACT_PIROUETTE, V_MIN, V_MAX, 9'd359, V_MAX}, 1'b0, NO_WANT},
        '{'{mwm_pkg::ACT_PIROUETTE, V_MAX, 16'sd0, 9'd45, 16'sd0}, 1'b0, NO_WANT},
        '{'{mwm_pkg::ACT_DRIVE, 16'sd1000, 16'sd0, 9'd0, -16'sd250}, 1'b0, NO_WANT},
        '{'{mwm_pkg::ACT_TRANSLATE, -16'sd1, 16'sd0, 9'd0, 16'sd0}, 1'b0, NO_WANT},
        '{'{mwm_pkg::ACT_STOP, 16'sd0, 16'sd0, 9'd0, V_MIN}, 1'b1, '0}
    };

    logic clk;
    logic rst_n;

    mwm_cmd_if   cmd ();
    mwm_wheel_if wheel ();
    mwm_cfg_if   cfg ();

    mecanum_wheel_mixer dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .wheel (wheel),
        .cfg   (cfg)
    );

    // Predictor state: copies of the three scale registers and the sine table
    mwm_pkg::scale_t speed_scale_q = mwm_pkg::SCALE_RESET;
    mwm_pkg::scale_t trans_scale_q = mwm_pkg::SCALE_RESET;
    mwm_pkg::scale_t spin_scale_q  = mwm_pkg::SCALE_RESET;
    longint sine_lut [0:90];

    wheel_word_t wheel_expect [$];

    // Typed expectation travels with the word on offer
    bit          offer_known;
    wheel_word_t offer_want;

    int  words_sent;
    int  words_seen;
    int  fail_count;
    int  act_seen [8];
    int  settings_done;
    int  long_holds;
    bit  tx_quiet;
    bit  rx_quiet;
    bit  long_hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAIL mecanum_wheel_mixer");
        $finish;
    end

    // Signed Q1.15 sine of a heading already in 0..359
    function automatic longint heading_sine(int unsigned h);
        int unsigned quad = h / 90;
        int unsigned rem  = h % 90;
        longint      mag  = (quad % 2 == 1) ? sine_lut[90 - rem] : sine_lut[rem];
        return (quad >= 2) ? -mag : mag;
    endfunction

    // Truncate toward zero by shift bits, then clamp to the drive range
    function automatic mwm_pkg::drive_t wheel_round(longint v, int shift);
        longint top = (longint'(1) <<< (mwm_pkg::DRIVE_BITS - 1)) - 1;
        longint q;
        q = (v < 0) ? -((-v) >>> shift) : (v >>> shift);
        if (q > top)
            q = top;
        else if (q < -top - 1)
            q = -top - 1;
        return mwm_pkg::drive_t'(q);
    endfunction

    function automatic wheel_word_t mix_wheels(motion_cmd_t c);
        longint      p     = longint'(signed'(c.primary));
        longint      sv    = longint'(signed'(c.spin));
        longint      y     = longint'(signed'(c.yaw));
        longint      ss    = longint'(speed_scale_q);
        longint      ts    = longint'(trans_scale_q);
        longint      ps    = longint'(spin_scale_q);
        longint      fl    = 0;
        longint      fr    = 0;
        longint      bl    = 0;
        longint      br    = 0;
        int          shift = mwm_pkg::SCALE_FRAC_BITS;
        int unsigned h     = c.heading;
        longint      vx;
        longint      vy;
        longint      w;
        wheel_word_t r;
        case (c.action)
            mwm_pkg::ACT_DRIVE:
            begin
                fl = (p - y) * ss;
                bl = fl;
                fr = (p + y) * ss;
                br = fr;
            end
            mwm_pkg::ACT_ROTATE:
            begin
                fl = p * ss;
                bl = fl;
                fr = -p * ss;
                br = fr;
            end
            mwm_pkg::ACT_TRANSLATE:
            begin
                fr = p * ts;
                bl = fr;
                fl = -p * ts;
                br = fl;
            end
            mwm_pkg::ACT_PIROUETTE:
            begin
                if (h >= 360)
                    h -= 360;
                vy = p * heading_sine(h);
                vx = p * heading_sine((h + 90 >= 360) ? h - 270 : h + 90);
                w  = sv * ps * (longint'(1) <<< mwm_pkg::TRIG_FRAC_BITS);
                fl = (vy - vx) * ts + w;
                bl = (vy + vx) * ts + w;
                fr = (vy + vx) * ts - w;
                br = (vy - vx) * ts - w;
                shift = mwm_pkg::SCALE_FRAC_BITS + mwm_pkg::TRIG_FRAC_BITS;
            end
            default: ;  // stop and the spare codes: all wheels zero
        endcase
        r.fl = wheel_round(fl, shift);
        r.fr = wheel_round(fr, shift);
        r.bl = wheel_round(bl, shift);
        r.br = wheel_round(br, shift);
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int idle_gap();
        int unsigned r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic mwm_pkg::value_t pick_value();
        int unsigned r = $urandom_range(0, 99);
        if (r < 6)
            return V_MAX;
        if (r < 12)
            return V_MIN;
        if (r < 15)
            return '0;
        if (r < 18)
            return mwm_pkg::value_t'(-1);
        if (r < 40)
            return mwm_pkg::value_t'(int'($urandom_range(0, 1023)) - 512);
        return mwm_pkg::value_t'($urandom);
    endfunction

    function automatic mwm_pkg::scale_t pick_scale();
        int unsigned r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        if (r < 24)
            return mwm_pkg::SCALE_RESET;
        if (r < 30)
            return mwm_pkg::scale_t'($urandom_range(0, 255));
        return mwm_pkg::scale_t'($urandom);
    endfunction

    // Offer one command word; valid stays up into the next word unless a gap follows
    task automatic offer_cmd(input motion_cmd_t c, input bit known, input wheel_word_t want);
        int gap;
        cmd.valid         <= 1'b1;
        cmd.action        <= c.action;
        cmd.primary_value <= c.primary;
        cmd.spin_value    <= c.spin;
        cmd.heading_deg   <= c.heading;
        cmd.yaw_trim      <= c.yaw;
        offer_known       <= known;
        offer_want        <= want;
        do
            @(posedge clk);
        while (cmd.ready !== 1'b1);
        words_sent++;
        gap = tx_quiet ? 0 : idle_gap();
        if (gap > 0)
        begin
            // junk on the payload while idle
            cmd.valid         <= 1'b0;
            cmd.action        <= mwm_pkg::action_t'($urandom);
            cmd.primary_value <= mwm_pkg::value_t'($urandom);
            cmd.spin_value    <= mwm_pkg::value_t'($urandom);
            cmd.heading_deg   <= mwm_pkg::heading_t'($urandom);
            cmd.yaw_trim      <= mwm_pkg::value_t'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending, wait for every wheel word, then let the pipe settle
    task automatic wait_results_done(input int settle);
        cmd.valid <= 1'b0;
        while (words_seen != words_sent)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Receiver: random ready with runs and gaps, plus requested long hold-offs
    initial
    begin
        int low_left;
        int high_left;
        wheel.ready = 1'b0;
        low_left    = 0;
        high_left   = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                low_left      = LONG_HOLD_CYCLES;
                long_holds++;
            end
            if (low_left > 0)
            begin
                wheel.ready <= 1'b0;
                low_left--;
            end
            else
            begin
                wheel.ready <= 1'b1;
                if (high_left > 0)
                    high_left--;
                else
                begin
                    high_left = $urandom_range(0, 15);
                    if (!rx_quiet && $urandom_range(0, 5) != 0)
                        low_left = idle_gap();
                end
            end
        end
    end

    // Monitor: tracks register writes, predicts at command accept, checks at wheel accept
    always @(posedge clk)
    begin
        motion_cmd_t taken;
        wheel_word_t got;
        wheel_word_t want;
        if (rst_n === 1'b1)
        begin
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
            begin
                case (cfg.index)
                    mwm_pkg::REG_SPEED_SCALE:     speed_scale_q = cfg.data;
                    mwm_pkg::REG_TRANSLATE_SCALE: trans_scale_q = cfg.data;
                    mwm_pkg::REG_SPIN_SCALE:      spin_scale_q  = cfg.data;
                    default: ;
                endcase
            end
            if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
            begin
                taken.action  = cmd.action;
                taken.primary = cmd.primary_value;
                taken.spin    = cmd.spin_value;
                taken.heading = cmd.heading_deg;
                taken.yaw     = cmd.yaw_trim;
                wheel_expect.push_back(offer_known ? offer_want : mix_wheels(taken));
                act_seen[cmd.action]++;
            end
            if (wheel.valid === 1'b1 && wheel.ready === 1'b1)
            begin
                words_seen++;
                got.fl = wheel.front_left_drive;
                got.fr = wheel.front_right_drive;
                got.bl = wheel.back_left_drive;
                got.br = wheel.back_right_drive;
                if (wheel_expect.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("wheel word with nothing expected: %0d %0d %0d %0d",
                                 $signed(got.fl), $signed(got.fr),
                                 $signed(got.bl), $signed(got.br));
                end
                else
                begin
                    want = wheel_expect.pop_front();
                    if (got.fl !== want.fl || got.fr !== want.fr ||
                        got.bl !== want.bl || got.br !== want.br)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"word %0d: want FL %0d FR %0d BL %0d BR %0d,",
                                      " got FL %0d FR %0d BL %0d BR %0d"},
                                     words_seen, $signed(want.fl), $signed(want.fr),
                                     $signed(want.bl), $signed(want.br),
                                     $signed(got.fl), $signed(got.fr),
                                     $signed(got.bl), $signed(got.br));
                    end
                end
            end
        end
    end

    initial
    begin
        u64_t                 ang;
        u64_t                 ang2;
        u64_t                 term;
        longint               acc;
        motion_cmd_t          rc;
        mwm_pkg::scale_t      s_val;
        mwm_pkg::scale_t      t_val;
        mwm_pkg::scale_t      w_val;
        mwm_pkg::cfg_index_t  cfg_idx [4];
        mwm_pkg::scale_t      cfg_val [4];
        int                   n_writes;
        int unsigned          pick;

        rst_n             = 1'b0;
        cmd.valid         = 1'b0;
        cmd.action        = mwm_pkg::ACT_STOP;
        cmd.primary_value = '0;
        cmd.spin_value    = '0;
        cmd.heading_deg   = '0;
        cmd.yaw_trim      = '0;
        cfg.valid         = 1'b0;
        cfg.index         = mwm_pkg::REG_SPEED_SCALE;
        cfg.data          = '0;
        offer_known       = 1'b0;
        offer_want        = '0;

        // Quarter-wave sine: Q30 Taylor series to x^17, rounded half up to Q1.15
        for (int k = 0; k <= 90; k++)
        begin
            ang  = (u64_t'(k) * PI_Q30 + 64'd90) / 64'd180;
            ang2 = (ang * ang) >> 30;
            term = ang;
            acc  = longint'(ang);
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * ang2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc -= longint'(term);
                else
                    acc += longint'(term);
            end
            if (acc < 0)
                acc = 0;
            sine_lut[k] = longint'((u64_t'(acc) + (64'd1 << (29 - mwm_pkg::TRIG_FRAC_BITS)))
                                   >> (30 - mwm_pkg::TRIG_FRAC_BITS));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
            offer_cmd(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            // registers change only with the pipe empty
            wait_results_done(8);
            case (phase)
                0:
                begin
                    s_val = '0; t_val = '0; w_val = '0;
                end
                1:
                begin
                    s_val = '1; t_val = '1; w_val = '1;
                end
                3:
                begin
                    s_val = '1; t_val = '0; w_val = '1;
                end
                4:
                begin
                    s_val = '0; t_val = '1; w_val = mwm_pkg::SCALE_RESET;
                end
                default:
                begin
                    s_val = pick_scale(); t_val = pick_scale(); w_val = pick_scale();
                end
            endcase
            cfg_idx[0] = mwm_pkg::REG_SPEED_SCALE;     cfg_val[0] = s_val;
            cfg_idx[1] = mwm_pkg::REG_TRANSLATE_SCALE; cfg_val[1] = t_val;
            cfg_idx[2] = mwm_pkg::REG_SPIN_SCALE;      cfg_val[2] = w_val;
            n_writes   = 3;
            if (phase == 3)
            begin
                // unmapped index last, so an aliasing write would show up
                cfg_idx[3] = REG_UNMAPPED;
                cfg_val[3] = mwm_pkg::scale_t'($urandom);
                n_writes   = 4;
            end
            for (int j = 0; j < n_writes; j++)
            begin
                cfg.valid <= 1'b1;
                cfg.index <= cfg_idx[j];
                cfg.data  <= cfg_val[j];
                do
                    @(posedge clk);
                while (cfg.ready !== 1'b1);
            end
            cfg.valid <= 1'b0;
            settings_done++;

            rx_quiet = (phase == 4);
            if (phase == 2 || phase == 5)
                long_hold_req = 1'b1;   // sender keeps offering into a blocked pipe

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 0)
                    tx_quiet = ($urandom_range(0, 3) == 0);
                if (phase == 3 && i == PHASE_ITEMS / 2)
                    wait_results_done(0);
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    rc.action = mwm_pkg::action_t'($urandom_range(ACT_RSVD_A, ACT_RSVD_C));
                else if (pick < 18)
                    rc.action = mwm_pkg::ACT_STOP;
                else if (pick < 45)
                    rc.action = mwm_pkg::ACT_PIROUETTE;
                else
                    rc.action = mwm_pkg::action_t'($urandom_range(mwm_pkg::ACT_DRIVE,
                                                                  mwm_pkg::ACT_TRANSLATE));
                rc.primary = pick_value();
                rc.spin    = pick_value();
                rc.yaw     = pick_value();
                if ($urandom_range(0, 4) == 0)
                    rc.heading = mwm_pkg::heading_t'($urandom_range(360, 511));
                else
                    rc.heading = mwm_pkg::heading_t'($urandom_range(0, 359));
                offer_cmd(rc, 1'b0, NO_WANT);
            end
        end

        wait_results_done(12);
        if (wheel_expect.size() != 0)
        begin
            fail_count += wheel_expect.size();
            $display("%0d wheel words never arrived", wheel_expect.size());
        end

        $display("covered %0d commands: stop %0d drive %0d rotate %0d translate %0d",
                 words_sent, act_seen[mwm_pkg::ACT_STOP], act_seen[mwm_pkg::ACT_DRIVE],
                 act_seen[mwm_pkg::ACT_ROTATE], act_seen[mwm_pkg::ACT_TRANSLATE]);
        $display("  pirouette %0d spare %0d; %0d scale settings, %0d long hold-offs, %0d checked",
                 act_seen[mwm_pkg::ACT_PIROUETTE],
                 act_seen[ACT_RSVD_A] + act_seen[ACT_RSVD_B] + act_seen[ACT_RSVD_C],
                 settings_done, long_holds, words_seen);
        if (fail_count == 0)
            $display("PASS mecanum_wheel_mixer");
        else
            $display("FAIL mecanum_wheel_mixer");
        $finish;
    end

endmodule
